@@ hdl/ecf_pkg.sv @@
// Shared types and constants for the envelope clipper with high-pass and low-pass filters.
package ecf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int ENV_W    = 23;
    localparam int GAIN_W   = 16;
    localparam int COEFF_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 23;
    localparam int HPM_W    = 26;
    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = 28;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int Y_W      = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS       = 2'd3;

    localparam logic [GAIN_W-1:0]  GAIN_RESET     = 16'd256;
    localparam logic [ENV_W-1:0]   FLOOR_RESET    = 23'd4096;
    localparam logic [COEFF_W-1:0] HIGHPASS_RESET = 16'd62000;
    localparam logic [COEFF_W-1:0] LOWPASS_RESET  = 16'd2800;

    typedef struct packed {
        logic load_in;
        logic mul_gain;
        logic clip;
        logic mul_hp;
        logic upd_hp;
        logic mul_lp;
        logic upd_lp;
    } ecf_cmd_t;

endpackage

@@ hdl/ecf_ctrl.sv @@
// Sequencer for the clip and filter steps, with the output handshake.
module ecf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output ecf_pkg::ecf_cmd_t cmd
);
    import ecf_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_GAIN = 7'b0000010,
        ST_CLIP = 7'b0000100,
        ST_HPM  = 7'b0001000,
        ST_HPU  = 7'b0010000,
        ST_LPM  = 7'b0100000,
        ST_LPU  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                cmd.mul_gain = 1'b1;
                state_next   = ST_CLIP;
            end
            ST_CLIP:
            begin
                cmd.clip   = 1'b1;
                state_next = ST_HPM;
            end
            ST_HPM:
            begin
                cmd.mul_hp = 1'b1;
                state_next = ST_HPU;
            end
            ST_HPU:
            begin
                cmd.upd_hp = 1'b1;
                state_next = ST_LPM;
            end
            ST_LPM:
            begin
                cmd.mul_lp = 1'b1;
                state_next = ST_LPU;
            end
            ST_LPU:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.upd_lp     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hdl/ecf_datapath.sv @@
// Configuration registers, shared multiplier, clipper and filter state.
module ecf_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ecf_pkg::ecf_cmd_t                      cmd,
    input  logic                                   cfg_write,
    input  logic [ecf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ecf_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic signed [ecf_pkg::SAMPLE_W-1:0]    sample_in,
    input  logic [ecf_pkg::ENV_W-1:0]              envelope,
    output logic signed [ecf_pkg::SAMPLE_W-1:0]    sample_out
);
    import ecf_pkg::*;

    localparam int AMP_W = 32;
    localparam int HPD_W = 28;
    localparam int LPS_W = 29;
    localparam int LSUM_W = 30;

    logic [GAIN_W-1:0]  gain_reg;
    logic [ENV_W-1:0]   floor_reg;
    logic [COEFF_W-1:0] hp_coeff_reg;
    logic [COEFF_W-1:0] lp_coeff_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic [ENV_W-1:0]           env_reg;
    logic [ENV_W-1:0]           ceil_reg;
    logic signed [SAMPLE_W-1:0] clip_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [Y_W-1:0]      y_reg;
    logic signed [HPM_W-1:0]    s_reg;
    logic signed [SAMPLE_W-1:0] l_reg, l_next;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  prod_next;

    logic signed [AMP_W-1:0]    amp;
    logic signed [AMP_W-1:0]    ceil_pos;
    logic signed [SAMPLE_W-1:0] clip_next;
    logic signed [Y_W-1:0]      y_next;
    logic signed [HPD_W-1:0]    hp_diff;
    logic signed [HPM_W-1:0]    s_next;
    logic signed [LPS_W-1:0]    lp_step;
    logic signed [LSUM_W-1:0]   l_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_RESET;
            floor_reg    <= FLOOR_RESET;
            hp_coeff_reg <= HIGHPASS_RESET;
            lp_coeff_reg <= LOWPASS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GAIN:          gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_CEILING_FLOOR: floor_reg    <= cfg_data[ENV_W-1:0];
                CFG_HIGHPASS:      hp_coeff_reg <= cfg_data[COEFF_W-1:0];
                CFG_LOWPASS:       lp_coeff_reg <= cfg_data[COEFF_W-1:0];
                default:           gain_reg     <= gain_reg;
            endcase
        end
    end

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (cmd.mul_gain)
        begin
            op_a = signed'({1'b0, gain_reg});
            op_b = MUL_B_W'(x_reg);
        end
        else if (cmd.mul_hp)
        begin
            op_a = signed'({1'b0, hp_coeff_reg});
            op_b = MUL_B_W'(s_reg) + MUL_B_W'(clip_reg);
        end
        else
        begin
            op_a = signed'({1'b0, lp_coeff_reg});
            op_b = MUL_B_W'(y_reg) - MUL_B_W'(l_reg);
        end
        prod_next = op_a * op_b;
    end

    always_comb
    begin
        amp      = prod_reg[AMP_W+7:8];
        ceil_pos = signed'(AMP_W'(ceil_reg));
        if (amp > ceil_pos)
            clip_next = SAMPLE_W'(ceil_pos);
        else if (amp < -ceil_pos)
            clip_next = SAMPLE_W'(-ceil_pos);
        else
            clip_next = SAMPLE_W'(amp);

        y_next  = prod_reg[Y_W+15:16];
        hp_diff = HPD_W'(y_next) - HPD_W'(clip_reg);
        if (hp_diff > HPD_W'(2**(HPM_W-1) - 1))
            s_next = {1'b0, {(HPM_W-1){1'b1}}};
        else if (hp_diff < -HPD_W'(2**(HPM_W-1)))
            s_next = {1'b1, {(HPM_W-1){1'b0}}};
        else
            s_next = HPM_W'(hp_diff);

        lp_step = prod_reg[PROD_W-1:16];
        l_sum   = LSUM_W'(l_reg) + LSUM_W'(lp_step);
        if (l_sum > LSUM_W'(2**(SAMPLE_W-1) - 1))
            l_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (l_sum < -LSUM_W'(2**(SAMPLE_W-1)))
            l_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            l_next = SAMPLE_W'(l_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
            l_reg <= '0;
        end
        else
        begin
            if (cmd.upd_hp)
                s_reg <= s_next;
            if (cmd.upd_lp)
                l_reg <= l_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg   <= sample_in;
            env_reg <= envelope;
        end
        if (cmd.mul_gain)
            ceil_reg <= (env_reg > floor_reg) ? env_reg : floor_reg;
        if (cmd.mul_gain || cmd.mul_hp || cmd.mul_lp)
            prod_reg <= prod_next;
        if (cmd.clip)
            clip_reg <= clip_next;
        if (cmd.upd_hp)
            y_reg <= y_next;
        if (cmd.upd_lp)
            out_reg <= l_next;
    end

    assign sample_out = out_reg;

endmodule

@@ hdl/envelope_clip_with_hpf_lpf_unit.sv @@
// Top level of the envelope clipper with one-pole high-pass and low-pass filters.
//
//   channel  signals                                  direction
//   input    in_valid, in_ready, sample_in, envelope  in
//   output   out_valid, out_ready, sample_out         out
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data in
//
// A transaction steps through gain, clip, high-pass and low-pass to the result register,
// and a new one is not accepted until the last one is through:
// one shared 17x28 multiplier is used three times (gain, high-pass, low-pass),
// each product registered before the clip or the state update that uses it.
// A new transaction is taken once the result is in the output register.
// Reset clears the filter state and loads the register defaults.
// A stalled output holds the last step until the output register drains.
module envelope_clip_with_hpf_lpf_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ecf_pkg::SAMPLE_W-1:0]    sample_in,
    input  logic [ecf_pkg::ENV_W-1:0]              envelope,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [ecf_pkg::SAMPLE_W-1:0]    sample_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ecf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ecf_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import ecf_pkg::*;

    ecf_cmd_t cmd;

    assign cfg_ready = 1'b1;

    ecf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ecf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_write  (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .envelope   (envelope),
        .sample_out (sample_out)
    );

endmodule
